// ===== sv/log_line_sanitizer_core_assert.svh =====
// Assertion macros for the log line sanitizer core.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef LOG_LINE_SANITIZER_CORE_ASSERT_SVH
`define LOG_LINE_SANITIZER_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define LLS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

// When the trigger holds, the consequence holds in the following cycle.
`define LLS_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/lls_pkg.sv =====
// Shared types, character constants and helpers for the log line sanitizer.
// No dependencies; used by lls_filter and log_line_sanitizer_core.
package lls_pkg;

	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_FINAL_LO = 8'h40;
	localparam logic [7:0] CH_FINAL_HI = 8'h7E;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	localparam logic [2:0] SEV_ERROR   = 3'd3;
	localparam logic [2:0] SEV_WARNING = 3'd4;
	localparam logic [2:0] SEV_INFO    = 3'd6;
	localparam logic [2:0] SEV_DEBUG   = 3'd7;

	localparam logic [4:0] FACILITY_USER = 5'd1;
	localparam logic [4:0] FACILITY_MAX  = 5'd23;
	localparam logic [8:0] CAPACITY_RESET = 9'd256;

	// Configuration register indexes.
	localparam logic REG_LINE_CAPACITY = 1'b0;
	localparam logic REG_FACILITY_CODE = 1'b1;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESC    = 2'd1,
		PH_CSI    = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] kept_count;
		logic [7:0] last_nonblank_end;
		logic [2:0] severity;
		logic       buffer_full;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		phase:             PH_NORMAL,
		kept_count:        8'd0,
		last_nonblank_end: 8'd0,
		severity:          SEV_INFO,
		buffer_full:       1'b0
	};

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_value;
		logic [7:0] char_index;
		logic       line_done;
		logic [7:0] trimmed_length;
		logic [7:0] syslog_priority;
	} line_result_t;

	function automatic logic [2:0] severity_of(input logic [7:0] ch);
		logic [2:0] sev;
		case (ch)
			8'h45:        sev = SEV_ERROR;
			8'h57:        sev = SEV_WARNING;
			8'h44, 8'h56: sev = SEV_DEBUG;
			default:      sev = SEV_INFO;
		endcase
		return sev;
	endfunction

endpackage

// ===== sv/lls_filter.sv =====
// Per-byte filter: escape tracking, keep decision, trim and priority for one item.
// Pure combinational; depends on lls_pkg for state and result types.
module lls_filter
	import lls_pkg::*;
(
	input  line_state_t  state,
	input  logic [7:0]   byte_value,
	input  logic         end_of_line,
	input  logic [8:0]   capacity,
	input  logic [4:0]   facility,
	output line_state_t  next_state,
	output line_result_t result,
	output logic         has_result
);

	logic       keep;
	logic       is_final;
	logic       printable;
	logic [8:0] count_plus;
	logic [4:0] fac_c;
	logic [2:0] sev;

	assign is_final   = byte_value inside {[CH_FINAL_LO:CH_FINAL_HI]};
	assign printable  = (byte_value inside {[CH_SPACE:CH_FINAL_HI]}) || (byte_value == CH_TAB);
	assign count_plus = {1'b0, state.kept_count} + 9'd1;
	assign fac_c      = (facility > FACILITY_MAX) ? FACILITY_MAX : facility;

	always_comb begin
		next_state = state;
		keep       = 1'b0;
		if (!state.buffer_full) begin
			case (state.phase)
				PH_ESC: begin
					if (byte_value == CH_LBRACKET) begin
						next_state.phase = PH_CSI;
					end else if (is_final) begin
						next_state.phase = PH_NORMAL;
					end
				end
				PH_CSI: begin
					if (is_final) begin
						next_state.phase = PH_NORMAL;
					end
				end
				default: begin
					// The unused phase code behaves as normal text.
					if (byte_value == CH_ESC) begin
						next_state.phase = PH_ESC;
					end else if (printable) begin
						if (count_plus >= capacity) begin
							next_state.buffer_full = 1'b1;
						end else begin
							keep = 1'b1;
							if (state.kept_count == 8'd0) begin
								next_state.severity = severity_of(byte_value);
							end
							next_state.kept_count = count_plus[7:0];
							if (byte_value != CH_SPACE && byte_value != CH_TAB) begin
								next_state.last_nonblank_end = count_plus[7:0];
							end
						end
					end
				end
			endcase
		end

		// The final byte itself counts toward the trimmed length and the severity.
		sev = (next_state.last_nonblank_end == 8'd0) ? SEV_INFO : next_state.severity;

		result.char_valid      = keep;
		result.char_value      = keep ? byte_value : 8'd0;
		result.char_index      = keep ? state.kept_count : 8'd0;
		result.line_done       = end_of_line;
		result.trimmed_length  = end_of_line ? next_state.last_nonblank_end : 8'd0;
		result.syslog_priority = end_of_line ? {fac_c, sev} : 8'd0;

		// The last byte of a line always returns the running state to its start.
		if (end_of_line) begin
			next_state = LINE_CLEAR;
		end
	end

	assign has_result = keep || end_of_line;

endmodule

// ===== sv/log_line_sanitizer_core.sv =====
// Log line sanitizer core: one byte per item, escape and control stripping, trim and priority.
// Throughput one item per cycle unless the output stalls; results are registered at the output.
// The per-line state updates as the item leaves the input register, so consecutive bytes
// stream without gaps; only a stalled output register holds the pipe.
// Reset clears the line state and both valid flags and restores capacity 256, facility 1.
// Depends on lls_pkg, lls_filter and log_line_sanitizer_core_assert.svh.
`include "log_line_sanitizer_core_assert.svh"

module log_line_sanitizer_core
	import lls_pkg::*;
#(
	parameter int LINE_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       char_valid,
	output logic [7:0] char_value,
	output logic [7:0] char_index,
	output logic       line_done,
	output logic [7:0] trimmed_length,
	output logic [7:0] syslog_priority,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	localparam logic [8:0] CAP_LIMIT = (LINE_BYTES < 256) ? 9'(LINE_BYTES) : 9'd256;

	logic [8:0]   line_capacity_q;
	logic [4:0]   facility_code_q;
	logic [8:0]   cap_eff;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	line_state_t  state_q;
	line_state_t  state_next;
	line_result_t result_c;
	line_result_t result_q;
	logic         has_result;
	logic         out_valid_q;
	logic         advance;
	logic         process;

	always_comb begin
		cap_eff = line_capacity_q;
		if (cap_eff == 9'd0) begin
			cap_eff = 9'd1;
		end
		if (cap_eff > CAP_LIMIT) begin
			cap_eff = CAP_LIMIT;
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign process  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_capacity_q <= CAPACITY_RESET;
			facility_code_q <= FACILITY_USER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_CAPACITY: line_capacity_q <= cfg_data;
				REG_FACILITY_CODE: facility_code_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
			last_s1 <= end_of_line;
		end
	end

	lls_filter u_filter (
		.state       (state_q),
		.byte_value  (byte_s1),
		.end_of_line (last_s1),
		.capacity    (cap_eff),
		.facility    (facility_code_q),
		.next_state  (state_next),
		.result      (result_c),
		.has_result  (has_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LINE_CLEAR;
		end else if (process) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= process && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (process && has_result) begin
			result_q <= result_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign char_valid      = result_q.char_valid;
	assign char_value      = result_q.char_value;
	assign char_index      = result_q.char_index;
	assign line_done       = result_q.line_done;
	assign trimmed_length  = result_q.trimmed_length;
	assign syslog_priority = result_q.syslog_priority;

	`LLS_ASSERT_ALWAYS(a_count_below_cap, ({1'b0, state_q.kept_count} < cap_eff))
	`LLS_ASSERT_ALWAYS(a_trim_within_count, (state_q.last_nonblank_end <= state_q.kept_count))
	`LLS_ASSERT_NEXT(a_line_end_clears, (process && last_s1),
		(state_q.kept_count == 8'd0 && !state_q.buffer_full && state_q.phase == PH_NORMAL))
	`LLS_ASSERT_NEXT(a_kept_index, (process && result_c.char_valid),
		(out_valid && char_valid && char_index == $past(state_q.kept_count)))

endmodule
